// ===== rtl/mtp_pkg.sv =====
// shared constants and datapath functions for the mersenne twister generator
`timescale 1ns / 1ps

package mtp_pkg;

  // table geometry
  localparam int unsigned STATE_WORDS_DEF = 624;
  localparam int unsigned SHIFT_WORDS     = 397;
  localparam int unsigned WORD_W          = 32;

  // recurrence, twist and tempering constants
  localparam logic [31:0] INIT_MULT  = 32'h6C07_8965;
  localparam logic [31:0] UPPER_MASK = 32'h8000_0000;
  localparam logic [31:0] LOWER_MASK = 32'h7FFF_FFFF;
  localparam logic [31:0] TWIST_XOR  = 32'h9908_B0DF;
  localparam logic [31:0] TEMPER_B   = 32'h9D2C_5680;
  localparam logic [31:0] TEMPER_C   = 32'hEFC6_0000;

  // input transaction kinds carried on tuser
  localparam logic OP_EXTRACT = 1'b0;
  localparam logic OP_SEED    = 1'b1;

  // next seeding word from the previous one and its position
  function automatic logic [31:0] seed_word(input logic [31:0] prev, input logic [31:0] pos);
    logic [31:0] mixed;
    mixed = prev ^ (prev >> 30);
    return (INIT_MULT * mixed) + pos;
  endfunction

  // twist of one word from itself, its successor and the word shift places ahead
  function automatic logic [31:0] twist_word(input logic [31:0] cur, input logic [31:0] nbr,
                                             input logic [31:0] far);
    logic [31:0] y;
    logic [31:0] w;
    y = (cur & UPPER_MASK) | (nbr & LOWER_MASK);
    w = far ^ (y >> 1);
    if (y[0]) begin
      w = w ^ TWIST_XOR;
    end
    return w;
  endfunction

  // output tempering
  function automatic logic [31:0] temper(input logic [31:0] y_in);
    logic [31:0] y;
    y = y_in;
    y = y ^ (y >> 11);
    y = y ^ ((y << 7) & TEMPER_B);
    y = y ^ ((y << 15) & TEMPER_C);
    y = y ^ (y >> 18);
    return y;
  endfunction

endpackage

// ===== rtl/mtp_ram.sv =====
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps

module mtp_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 624
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/mersenne_twister_prng_unit.sv =====
// mt19937 generator top level: table sequencer, seeding, per-word twist and tempering
// extract: three reads of the table on its one read port (word, successor, word shift ahead),
//   then ST_WRITE, which waits while the output is busy; no new transaction is taken before it
//   ends. seed: word 0 from seed_value, then one word per cycle via the recurrence multiplier
// reset (synchronous, rst_n low): a clearing pass zeroes all 624 table words, one a cycle,
//   with in_tready low; the read index starts at zero
`timescale 1ns / 1ps

module mersenne_twister_prng_unit
  import mtp_pkg::*;
#(
  parameter int unsigned STATE_WORDS = STATE_WORDS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] seed_value
  input  logic        in_tuser,   // [0] opcode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata   // [31:0] random_word
);

  localparam int unsigned IDX_W = $clog2(STATE_WORDS);

  // sequencer states
  localparam logic [2:0] ST_CLEAR   = 3'd0;
  localparam logic [2:0] ST_IDLE    = 3'd1;
  localparam logic [2:0] ST_SEED    = 3'd2;
  localparam logic [2:0] ST_RD_CUR  = 3'd3;
  localparam logic [2:0] ST_RD_NBR  = 3'd4;
  localparam logic [2:0] ST_RD_FAR  = 3'd5;
  localparam logic [2:0] ST_WRITE   = 3'd6;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(STATE_WORDS - 1);

  logic [2:0]        state_r, state_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic [IDX_W-1:0]  cnt_r, cnt_nxt;
  logic [31:0]       prev_r, prev_nxt;
  logic [31:0]       cur_r, cur_nxt;
  logic [31:0]       nbr_r, nbr_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [31:0]       out_data_r, out_data_nxt;

  logic              ram_we;
  logic [IDX_W-1:0]  ram_waddr;
  logic [31:0]       ram_wdata;
  logic [IDX_W-1:0]  ram_raddr;
  logic [31:0]       ram_rdata;

  logic              in_fire;
  logic              out_free;
  logic [IDX_W-1:0]  idx_succ;
  logic [IDX_W:0]    far_sum;
  logic [IDX_W-1:0]  far_idx;
  logic [31:0]       seed_next;
  logic [31:0]       twisted;

  assign in_tready  = (state_r == ST_IDLE);
  assign in_fire    = in_tvalid && in_tready;
  assign out_free   = !out_valid_r || out_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // neighbor addresses of the current read index
  assign idx_succ  = (idx_r == LAST_IDX) ? '0 : idx_r + 1'b1;
  assign far_sum   = {1'b0, idx_r} + (IDX_W + 1)'(SHIFT_WORDS);
  assign far_idx   = (far_sum >= (IDX_W + 1)'(STATE_WORDS)) ?
                     IDX_W'(far_sum - (IDX_W + 1)'(STATE_WORDS)) : far_sum[IDX_W-1:0];

  // datapath words
  assign seed_next = seed_word(prev_r, 32'(cnt_r));
  assign twisted   = twist_word(cur_r, nbr_r, ram_rdata);

  // sequencer and table port control
  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    cnt_nxt       = cnt_r;
    prev_nxt      = prev_r;
    cur_nxt       = cur_r;
    nbr_nxt       = nbr_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    ram_we        = 1'b0;
    ram_waddr     = cnt_r;
    ram_wdata     = '0;
    ram_raddr     = idx_r;
    case (state_r)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = cnt_r;
        ram_wdata = '0;
        cnt_nxt   = cnt_r + 1'b1;
        if (cnt_r == LAST_IDX) begin
          cnt_nxt   = '0;
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_fire) begin
          if (in_tuser == OP_SEED) begin
            ram_we    = 1'b1;
            ram_waddr = '0;
            ram_wdata = in_tdata;
            prev_nxt  = in_tdata;
            cnt_nxt   = IDX_W'(1);
            idx_nxt   = '0;
            state_nxt = ST_SEED;
          end else begin
            state_nxt = ST_RD_CUR;
          end
        end
      end
      ST_SEED: begin
        ram_we    = 1'b1;
        ram_waddr = cnt_r;
        ram_wdata = seed_next;
        prev_nxt  = seed_next;
        cnt_nxt   = cnt_r + 1'b1;
        if (cnt_r == LAST_IDX) begin
          cnt_nxt   = '0;
          state_nxt = ST_IDLE;
        end
      end
      ST_RD_CUR: begin
        ram_raddr = idx_r;
        state_nxt = ST_RD_NBR;
      end
      ST_RD_NBR: begin
        ram_raddr = idx_succ;
        cur_nxt   = ram_rdata;
        state_nxt = ST_RD_FAR;
      end
      ST_RD_FAR: begin
        ram_raddr = far_idx;
        nbr_nxt   = ram_rdata;
        state_nxt = ST_WRITE;
      end
      ST_WRITE: begin
        // hold the far read so its data stays put while the output is busy
        ram_raddr = far_idx;
        if (out_free) begin
          ram_we        = 1'b1;
          ram_waddr     = idx_r;
          ram_wdata     = twisted;
          out_valid_nxt = 1'b1;
          out_data_nxt  = temper(twisted);
          idx_nxt       = idx_succ;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      idx_r       <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    prev_r     <= prev_nxt;
    cur_r      <= cur_nxt;
    nbr_r      <= nbr_nxt;
    out_data_r <= out_data_nxt;
  end

  // state table
  mtp_ram #(
    .WIDTH (WORD_W),
    .DEPTH (STATE_WORDS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule

// ===== bench/tb_mersenne_twister_prng_unit.sv =====
// self-checking stream testbench for the mt19937 generator with its own prediction of the table
`timescale 1ns / 1ps

module tb_mersenne_twister_prng_unit
  import mtp_pkg::*;
();

  localparam int unsigned RANDOM_ITEMS   = 1900;
  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned DRAIN_CYCLES   = 40;
  localparam int unsigned MAX_REPORTS    = 10;

  typedef struct packed {
    logic        op;
    logic [31:0] seed;
  } gen_req_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;    // [31:0] seed_value
  logic        in_tuser = OP_EXTRACT;  // [0] opcode
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;        // [31:0] random_word

  // stimulus and expected words
  gen_req_t    pending_reqs[$];
  gen_req_t    cur_req;
  logic [31:0] expected_words[$];

  // predicted generator state
  logic [31:0] mt_words [0:STATE_WORDS_DEF-1];
  int unsigned mt_pos;

  int unsigned in_gap = 0;
  int unsigned in_calm = 0;
  int unsigned out_wait = 0;
  int unsigned out_calm = 0;
  int unsigned idle_cycles = 0;
  int unsigned fail_count = 0;
  logic        timed_out = 1'b0;

  mersenne_twister_prng_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  // clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // tempering of one table word
  function automatic logic [31:0] temper_word(input logic [31:0] raw);
    logic [31:0] t;
    t = raw ^ (raw >> 11);
    t = t ^ ((t << 7) & TEMPER_B);
    t = t ^ ((t << 15) & TEMPER_C);
    t = t ^ (t >> 18);
    return t;
  endfunction

  // in-place twist of the whole predicted table, lowest index first
  task automatic twist_table();
    logic [31:0] mix;
    logic [31:0] nw;
    int unsigned k;
    for (k = 0; k < STATE_WORDS_DEF; k++) begin
      mix = {mt_words[k][31], mt_words[(k + 1) % STATE_WORDS_DEF][30:0]};
      nw  = mt_words[(k + SHIFT_WORDS) % STATE_WORDS_DEF] ^ {1'b0, mix[31:1]};
      if (mix[0]) begin
        nw = nw ^ TWIST_XOR;
      end
      mt_words[k] = nw;
    end
  endtask

  // update the predicted state for one accepted transaction, queue the word it yields
  task automatic predict_req(input gen_req_t req);
    logic [31:0] p;
    int unsigned k;
    if (req.op == OP_SEED) begin
      mt_words[0] = req.seed;
      for (k = 1; k < STATE_WORDS_DEF; k++) begin
        p = mt_words[k - 1];
        mt_words[k] = INIT_MULT * (p ^ {30'd0, p[31:30]}) + k;
      end
      mt_pos = 0;
    end else begin
      if (mt_pos == 0) begin
        twist_table();
      end
      expected_words.push_back(temper_word(mt_words[mt_pos]));
      mt_pos = (mt_pos + 1) % STATE_WORDS_DEF;
    end
  endtask

  // wait before the next transaction, with runs of back-to-back transactions
  function automatic int unsigned draw_wait(inout int unsigned calm);
    int unsigned w;
    if (calm > 0) begin
      calm--;
      w = 0;
    end else if ($urandom_range(0, 19) == 0) begin
      calm = $urandom_range(10, 40);
      w = 0;
    end else begin
      w = $urandom_range(0, 9);
    end
    return w;
  endfunction

  function automatic logic [31:0] pick_seed();
    case ($urandom_range(0, 7))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  task automatic add_req(input logic op, input logic [31:0] v);
    gen_req_t r;
    r.op   = op;
    r.seed = v;
    pending_reqs.push_back(r);
  endtask

  // input driver
  always @(posedge clk) begin : in_driver
    logic        drive_v;
    int unsigned gap_n;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata  <= '0;
      in_tuser  <= OP_EXTRACT;
      in_gap    <= $urandom_range(0, 9);
    end else begin
      drive_v = in_tvalid;
      gap_n   = in_gap;
      if (in_tvalid && in_tready) begin
        predict_req(cur_req);
        drive_v = 1'b0;
        gap_n   = draw_wait(in_calm);
      end
      if (!drive_v) begin
        if (gap_n > 0) begin
          gap_n--;
        end else if (pending_reqs.size() > 0) begin
          cur_req  = pending_reqs.pop_front();
          drive_v  = 1'b1;
          in_tdata <= cur_req.seed;
          in_tuser <= cur_req.op;
        end
      end
      in_tvalid <= drive_v;
      in_gap    <= gap_n;
    end
  end

  // result monitor and checker
  always @(posedge clk) begin : out_monitor
    logic [31:0] exp_w;
    int unsigned wait_n;
    if (!rst_n) begin
      out_tready <= 1'b0;
      out_wait   <= $urandom_range(0, 9);
    end else begin
      wait_n = out_wait;
      if (out_tvalid && out_tready) begin
        if (expected_words.size() == 0) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS) begin
            $display("unexpected transaction: random_word %h", out_tdata);
          end
        end else begin
          exp_w = expected_words.pop_front();
          if (out_tdata !== exp_w) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS) begin
              $display("random_word mismatch: expected %h, got %h", exp_w, out_tdata);
            end
          end
        end
        wait_n = draw_wait(out_calm);
      end else if (wait_n > 0) begin
        wait_n--;
      end
      out_tready <= (wait_n == 0);
      out_wait   <= wait_n;
    end
  end

  // watchdog on cycles without any accepted transaction
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      timed_out <= 1'b1;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // stimulus, reset and end of run
  initial begin : stim
    int unsigned total;
    int unsigned n;
    int unsigned k;
    foreach (mt_words[i]) begin
      mt_words[i] = '0;
    end
    mt_pos = 0;

    // unseeded table gives zeros, seed_value ignored on extract
    add_req(OP_EXTRACT, 32'h0000_0000);
    add_req(OP_EXTRACT, 32'hFFFF_FFFF);
    add_req(OP_EXTRACT, $urandom);
    // standard default seed
    add_req(OP_SEED, 32'd5489);
    add_req(OP_EXTRACT, 32'hFFFF_FFFF);
    add_req(OP_EXTRACT, 32'h0000_0000);
    add_req(OP_EXTRACT, $urandom);
    add_req(OP_EXTRACT, $urandom);
    // extreme seeds, reseed mid-stream
    add_req(OP_SEED, 32'h0000_0000);
    add_req(OP_EXTRACT, $urandom);
    add_req(OP_EXTRACT, $urandom);
    add_req(OP_SEED, 32'hFFFF_FFFF);
    add_req(OP_EXTRACT, 32'h0000_0000);
    add_req(OP_EXTRACT, 32'hFFFF_FFFF);
    // back-to-back seeds, the second wins
    add_req(OP_SEED, 32'h8000_0000);
    add_req(OP_SEED, 32'h7FFF_FFFF);
    add_req(OP_EXTRACT, $urandom);
    add_req(OP_EXTRACT, $urandom);
    add_req(OP_SEED, 32'd1);
    add_req(OP_EXTRACT, $urandom);

    // random seed-then-extract runs, some long enough to wrap past the table end
    total = 0;
    while (total < RANDOM_ITEMS) begin
      add_req(OP_SEED, pick_seed());
      total++;
      if ($urandom_range(0, 3) == 0) begin
        n = $urandom_range(625, 700);
      end else begin
        n = $urandom_range(0, 40);
      end
      // keep the total near the item budget
      if (n > RANDOM_ITEMS - total) begin
        n = RANDOM_ITEMS - total;
      end
      for (k = 0; k < n; k++) begin
        add_req(OP_EXTRACT, $urandom);
      end
      total += n;
    end
    add_req(OP_EXTRACT, $urandom);

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    wait (timed_out ||
          (pending_reqs.size() == 0 && !in_tvalid && expected_words.size() == 0));
    if (!timed_out) begin
      repeat (DRAIN_CYCLES) @(posedge clk);
    end
    if (!timed_out && fail_count == 0 && expected_words.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/mtp_pkg.sv
rtl/mtp_ram.sv
rtl/mersenne_twister_prng_unit.sv
bench/tb_mersenne_twister_prng_unit.sv
